// ===== rtl/core/sha256_message_digest_defines.svh =====
// Assertion macros shared by the SHA-256 digest checker.
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH

// A condition that must imply another one in the same cycle.
`define SHA_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
	else $error(msg);

// A condition that must imply another one in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
	else $error(msg);

`endif

// ===== rtl/core/sha_pkg.sv =====
// Package with SHA-256 constants, functions and shared types.
`default_nettype none
package sha_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_COMP,
		ST_OUT
	} sha_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       take_byte;   // write one message byte
		logic       pad_write;   // write one padding byte at the fill pointer
		logic       len_write;   // write one length byte
		logic [2:0] len_sel;     // which length byte
		logic       comp_start;  // load working state and clear the round counter
		logic       comp_round;  // run one round
		logic       comp_finish; // add working state into hash
		logic       hash_reset;  // return hash and count to initial values
		logic       out_valid;   // digest words shown on the output
	} sha_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [5:0] fill_pos;    // next buffer position
		logic       round_last;  // final round is running
	} sha_stat_t;

	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha_ctrl.sv =====
// Controller state machine for the SHA-256 digest block.
`default_nettype none
module sha_ctrl
	import sha_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire logic      byte_present,
	input  wire logic      last,
	output logic           out_valid,
	input  wire logic      out_stall,
	output logic [2:0]     word_index,
	output sha_cmd_t       cmd,
	input  sha_stat_t      stat
);

	sha_state_t state_q, state_d;
	logic       last_pend_q, last_pend_d;   // padding follows the running compression
	logic       second_q, second_d;         // length goes into a second block
	logic [2:0] len_q, len_d;
	logic [2:0] widx_q, widx_d;
	logic       final_block_q;              // running compression closes the message

	assign word_index = widx_q;
	assign out_valid = (state_q == ST_OUT);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_pend_q <= 1'b0;
			second_q    <= 1'b0;
			len_q       <= '0;
			widx_q      <= '0;
		end else begin
			state_q     <= state_d;
			last_pend_q <= last_pend_d;
			second_q    <= second_d;
			len_q       <= len_d;
			widx_q      <= widx_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		last_pend_d = last_pend_q;
		second_d    = second_q;
		len_d       = len_q;
		widx_d      = widx_q;
		cmd         = '0;
		in_stall    = 1'b1;
		cmd.out_valid = (state_q == ST_OUT);
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take_byte = byte_present;
					if (byte_present && stat.fill_pos == 6'd63) begin
						cmd.comp_start = 1'b1;
						last_pend_d    = last;
						state_d        = ST_COMP;
					end else if (last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				// First padding byte is the marker, then zero fill.
				cmd.pad_write = 1'b1;
				if (stat.fill_pos == 6'd55) begin
					len_d   = '0;
					state_d = ST_LEN;
				end else if (stat.fill_pos == 6'd63) begin
					cmd.comp_start = 1'b1;
					second_d       = 1'b1;
					state_d        = ST_COMP;
				end
			end
			ST_LEN: begin
				cmd.len_write = 1'b1;
				cmd.len_sel   = len_q;
				len_d         = len_q + 3'd1;
				if (len_q == 3'd7) begin
					cmd.comp_start = 1'b1;
					second_d       = 1'b0;
					last_pend_d    = 1'b0;
					state_d        = ST_COMP;
					widx_d         = '0;
				end
			end
			ST_COMP: begin
				cmd.comp_round = 1'b1;
				if (stat.round_last) begin
					cmd.comp_finish = 1'b1;
					if (last_pend_q) begin
						last_pend_d = 1'b0;
						state_d     = ST_PAD;
					end else if (second_q) begin
						state_d = ST_PAD;
					end else if (final_block_q) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					widx_d = widx_q + 3'd1;
					if (widx_q == 3'd7) begin
						cmd.hash_reset = 1'b1;
						state_d        = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Marks the compression that closes a message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_block_q <= 1'b0;
		end else if (state_q == ST_LEN && len_q == 3'd7) begin
			final_block_q <= 1'b1;
		end else if (state_q == ST_COMP && stat.round_last) begin
			final_block_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sha_datapath.sv =====
// Datapath for the SHA-256 digest block: buffer, schedule, rounds, hash.
`default_nettype none
module sha_datapath
	import sha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  data_byte,
	input  sha_cmd_t         cmd,
	output sha_stat_t        stat,
	input  wire logic [2:0]  word_index,
	output logic [31:0]      digest_word
);

	logic [60:0] count_q;
	logic [5:0]  fill_q;          // pointer for padding writes
	logic        pad_first_q;     // next padding byte is the marker
	logic [31:0] hash_q [8];
	logic [31:0] work_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  round_q;
	logic [63:0] bits;
	logic        wr_en;
	logic [5:0]  wr_addr;
	logic [7:0]  wr_data;

	assign bits = {count_q, 3'b000};
	assign stat.fill_pos   = cmd.take_byte ? count_q[5:0] : fill_q;
	assign stat.round_last = (round_q == 6'(Rounds - 1));
	assign digest_word     = hash_q[word_index];

	// Byte write into the block: message byte, padding byte or length byte.
	always_comb begin
		wr_en   = cmd.take_byte | cmd.pad_write | cmd.len_write;
		wr_addr = count_q[5:0];
		wr_data = data_byte;
		if (cmd.pad_write) begin
			wr_addr = fill_q;
			wr_data = pad_first_q ? PadByte : 8'h00;
		end else if (cmd.len_write) begin
			wr_addr = 6'd56 + {3'd0, cmd.len_sel};
			wr_data = bits[{~cmd.len_sel, 3'b000} +: 8];
		end
	end

	// Byte count and fill pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fill_q      <= '0;
			pad_first_q <= 1'b1;
		end else if (cmd.hash_reset) begin
			count_q     <= '0;
			fill_q      <= '0;
			pad_first_q <= 1'b1;
		end else if (cmd.take_byte) begin
			count_q <= count_q + 61'd1;
			fill_q  <= count_q[5:0] + 6'd1;
		end else if (cmd.pad_write) begin
			fill_q      <= fill_q + 6'd1;
			pad_first_q <= 1'b0;
		end
	end

	// Schedule word and round function.
	logic [31:0] s0w, s1w, wnew, t1, t2, ch, mj;
	always_comb begin
		s0w  = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1w  = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = s1w + w_q[9] + s0w + w_q[0];
		ch   = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		mj   = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1   = work_q[7] + (rotr(work_q[4], 6) ^ rotr(work_q[4], 11) ^ rotr(work_q[4], 25))
			+ ch + RoundK[round_q] + w_q[0];
		t2   = (rotr(work_q[0], 2) ^ rotr(work_q[0], 13) ^ rotr(work_q[0], 22)) + mj;
	end

	// Round counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd.comp_start) begin
			round_q <= '0;
		end else if (cmd.comp_round) begin
			round_q <= round_q + 6'd1;
		end
	end

	// The schedule window doubles as the block buffer: bytes fill it big-endian,
	// and during the rounds it shifts in new schedule words.
	always_ff @(posedge clk) begin
		if (cmd.comp_round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end else if (wr_en) begin
			w_q[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
		end
	end

	// Working state.
	always_ff @(posedge clk) begin
		if (cmd.comp_start) begin
			for (int i = 0; i < 8; i++) work_q[i] <= hash_q[i];
		end else if (cmd.comp_round) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	// Hash state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
		end else if (cmd.hash_reset) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
		end else if (cmd.comp_finish) begin
			hash_q[0] <= hash_q[0] + t1 + t2;
			hash_q[1] <= hash_q[1] + work_q[0];
			hash_q[2] <= hash_q[2] + work_q[1];
			hash_q[3] <= hash_q[3] + work_q[2];
			hash_q[4] <= hash_q[4] + work_q[3] + t1;
			hash_q[5] <= hash_q[5] + work_q[4];
			hash_q[6] <= hash_q[6] + work_q[5];
			hash_q[7] <= hash_q[7] + work_q[6];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sha256_message_digest.sv =====
// SHA-256 message digest, one byte per request: each full 64-byte block stalls
// the input while one compression round runs per cycle; the final request adds
// padding and length writes and one or two block compressions, then the eight
// digest words leave one per cycle while out_stall is low, most significant first.
`default_nettype none
module sha256_message_digest
	import sha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	sha_cmd_t  cmd;
	sha_stat_t stat;

	assign last_word = (word_index == 3'd7);

	// Controller.
	sha_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .byte_present, .last,
		.out_valid, .out_stall, .word_index, .cmd, .stat
	);

	// Datapath.
	sha_datapath u_dp (
		.clk, .arst_n, .data_byte, .cmd, .stat, .word_index, .digest_word
	);

endmodule
`default_nettype wire

// ===== rtl/core/sha_checker.sv =====
// Port-level checker for the SHA-256 digest block, bound to the top level.
`default_nettype none
`include "sha256_message_digest_defines.svh"
module sha_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] digest_word,
	input wire logic [2:0]  word_index,
	input wire logic        last_word
);

	// The last mark appears only on word seven.
	`SHA_ASSERT_IMPLY(a_last_word, clk, arst_n, out_valid, last_word == (word_index == 3'd7), "last_word mismatch")
	// Input is never taken while a digest is shown.
	`SHA_ASSERT_IMPLY(a_no_overlap, clk, arst_n, out_valid, in_stall, "input open during output")
	// Accepted words advance the index by one.
	`SHA_ASSERT_NEXT(a_index_step, clk, arst_n, out_valid && !out_stall && !last_word, out_valid && word_index == $past(word_index) + 3'd1, "index did not step")
	// A stalled word holds.
	`SHA_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(digest_word), "stalled word changed")

endmodule

bind sha256_message_digest sha_checker u_sha_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall,
	.digest_word, .word_index, .last_word
);
`default_nettype wire

// ===== bench/sha256_digest_checker.sv =====
// Checker that predicts SHA-256 digest words and compares them with the block's output.
`timescale 1ns / 1ps
`default_nettype none
module sha256_digest_checker
	import sha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        last,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [31:0] digest_word,
	input  wire logic [2:0]  word_index,
	input  wire logic        last_word,
	output int               fail_count,
	output int               pending_words
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        is_last;
	} digest_out_t;

	localparam logic [31:0] StartHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0] chain_hash [8];
	logic [7:0]  block_buf [64];
	logic [60:0] msg_bytes;
	digest_out_t expected_words [$];

	initial begin
		fail_count = 0;
		pending_words = 0;
		chain_hash = StartHash;
		msg_bytes = '0;
		foreach (block_buf[i]) block_buf[i] = '0;
	end

	function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// One 64-round compression of the buffered block into the chaining hash.
	task automatic compress_buffer();
		logic [31:0] sched [64];
		logic [31:0] wk [8];
		logic [31:0] t1, t2, x, y;
		for (int t = 0; t < 16; t++)
			sched[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			x = sched[t-15];
			y = sched[t-2];
			sched[t] = (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10)) + sched[t-7]
				+ (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + sched[t-16];
		end
		wk = chain_hash;
		for (int t = 0; t < 64; t++) begin
			t1 = wk[7] + (ror32(wk[4], 6) ^ ror32(wk[4], 11) ^ ror32(wk[4], 25))
				+ ((wk[4] & wk[5]) ^ (~wk[4] & wk[6])) + RoundK[t] + sched[t];
			t2 = (ror32(wk[0], 2) ^ ror32(wk[0], 13) ^ ror32(wk[0], 22))
				+ ((wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]));
			wk[7] = wk[6]; wk[6] = wk[5]; wk[5] = wk[4]; wk[4] = wk[3] + t1;
			wk[3] = wk[2]; wk[2] = wk[1]; wk[1] = wk[0]; wk[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain_hash[i] += wk[i];
	endtask

	// Absorb one request; a closing request pads the message and queues the digest.
	task automatic absorb_request(input logic [7:0] b, input logic present, input logic fin);
		int pos;
		logic [63:0] bit_len;
		digest_out_t d;
		if (present) begin
			block_buf[msg_bytes[5:0]] = b;
			msg_bytes = msg_bytes + 1'b1;
			if (msg_bytes[5:0] == 0) compress_buffer();
		end
		if (fin) begin
			pos = msg_bytes[5:0];
			block_buf[pos] = PadByte;
			for (int i = pos + 1; i < 64; i++) block_buf[i] = '0;
			if (pos >= 56) begin
				compress_buffer();
				for (int i = 0; i < 56; i++) block_buf[i] = '0;
			end
			bit_len = {msg_bytes, 3'b000};
			for (int i = 0; i < 8; i++) block_buf[63-i] = bit_len[8*i +: 8];
			compress_buffer();
			for (int i = 0; i < 8; i++) begin
				d.word = chain_hash[i];
				d.index = 3'(i);
				d.is_last = (i == 7);
				expected_words.push_back(d);
			end
			chain_hash = StartHash;
			msg_bytes = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: digest mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Watch both channels at each rising edge.
	always @(posedge clk) begin
		digest_out_t e;
		if (arst_n && in_valid && !in_stall)
			absorb_request(data_byte, byte_present, last);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", digest_word, '0);
			end else begin
				e = expected_words.pop_front();
				if (digest_word !== e.word) report_mismatch("digest_word", digest_word, e.word);
				if (word_index !== e.index) report_mismatch("word_index", word_index, e.index);
				if (last_word !== e.is_last) report_mismatch("last_word", last_word, e.is_last);
			end
		end
		pending_words = expected_words.size();
	end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Top of the SHA-256 digest testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count;
	int          pending_words;
	int          cycle_count;
	bit          calm_phase;
	bit          hold_off;
	int          request_count;

	localparam int CycleLimit = 400000;

	sha256_message_digest u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .byte_present(byte_present), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	sha256_digest_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .byte_present(byte_present), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word),
		.fail_count(fail_count), .pending_words(pending_words)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Receiver: random stalls, a long hold-off when asked, none during the calm phase.
	initial out_stall = 1'b0;
	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else if (calm_phase) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(99) < 34);
	end

	// Drive one request and hold it until it is accepted; idle gaps come first.
	task automatic send_request(input logic [7:0] b, input logic present, input logic fin);
		if (!calm_phase)
			while ($urandom_range(99) < 34) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_present <= present;
		last <= fin;
		@(posedge clk iff !in_stall);
		@(negedge clk);
		request_count++;
	endtask

	// A whole message of random bytes, closed either on the last byte or by an empty item.
	task automatic send_message(input int len);
		bit empty_close;
		empty_close = (len == 0) || $urandom_range(1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
			send_request(8'($urandom), 1'b1, !empty_close && (i == len - 1));
		end
		if (empty_close) send_request(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		in_valid = 1'b0;
		data_byte = '0;
		byte_present = 1'b0;
		last = 1'b0;
		calm_phase = 1'b0;
		hold_off = 1'b0;
		request_count = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty message, ignored item, extreme bytes, padding boundaries.
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'hff, 1'b0, 1'b0);
		send_request(8'hff, 1'b1, 1'b1);
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'h5a, 1'b0, 1'b1);
		send_message(55);
		send_message(56);
		send_message(63);
		send_message(64);

		// Long hold-off on the receiver while messages keep coming.
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				send_message(3);
				send_message(0);
				send_message(5);
			end
		join

		// Random messages, mostly short, with a calm stretch in the middle.
		for (int m = 0; m < 10; m++) begin
			calm_phase = (m >= 3 && m < 7);
			send_message(($urandom_range(9) == 0) ? $urandom_range(129) : $urandom_range(20));
		end
		calm_phase = 1'b0;
		in_valid <= 1'b0;

		while (pending_words != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) $display("testbench OK");
		else $display("testbench NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
